### hdl/weighted_random_vc_allocator_defines.svh
// ----------------------------------------------------------------------------
// Weighted random VC allocator - assertion macros
// Shared concurrent assertion forms for the allocator's checks.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_VC_ALLOCATOR_DEFINES_SVH
`define WEIGHTED_RANDOM_VC_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define WRVA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define WRVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wrva_pkg.sv
// ----------------------------------------------------------------------------
// Weighted random VC allocator - package
// Sizes, status codes and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package wrva_pkg;

  // Design sizes
  localparam int NUM_QUEUES  = 8;
  localparam int WEIGHT_BITS = 8;
  localparam int RANDOM_BITS = 16;

  // Fixed field widths of the channels
  localparam int LANE_W     = 8;
  localparam int WEIGHTS_W  = 64;
  localparam int MASK_W     = 8;
  localparam int DRAW_W     = 16;
  localparam int QUEUE_W    = 3;
  localparam int STATUS_W   = 2;

  // Derived widths
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SUM_W  = WEIGHT_BITS + $clog2(NUM_QUEUES);
  localparam int PROD_W = RANDOM_BITS + SUM_W;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FLOW_PINNED     = 1'b0;
  localparam logic REG_QUEUE_EXCLUSIVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 2'd0,
    ST_NO_ELIG  = 2'd1,
    ST_NO_ROUTE = 2'd2
  } status_e;

  typedef struct packed {
    logic flow_pinned;
    logic queue_exclusive;
  } cfg_t;

  typedef struct packed {
    logic [WEIGHTS_W-1:0] route_weights;
    logic [MASK_W-1:0]    queue_empty_mask;
    logic [MASK_W-1:0]    queue_claimed_mask;
    logic [MASK_W-1:0]    queue_open_mask;
    logic [MASK_W-1:0]    holds_flow_mask;
    logic [DRAW_W-1:0]    random_draw;
  } req_t;

  // Candidates and cumulative weights after the eligibility scan
  typedef struct packed {
    status_e                              status;
    logic [NUM_QUEUES-1:0]                cand;
    logic [NUM_QUEUES-1:0][SUM_W-1:0]     cum;
    logic [SUM_W-1:0]                     sum;
    logic [RANDOM_BITS-1:0]               draw;
  } mid_t;

  typedef struct packed {
    status_e             status;
    logic [QIDX_W-1:0]   queue;
  } res_t;

endpackage

`default_nettype wire

### hdl/wrva_req_if.sv
// ----------------------------------------------------------------------------
// Weighted random VC allocator - request channel
// Valid/ready channel carrying one allocation request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrva_req_if;
  import wrva_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WEIGHTS_W-1:0] route_weights;
  logic [MASK_W-1:0]    queue_empty_mask;
  logic [MASK_W-1:0]    queue_claimed_mask;
  logic [MASK_W-1:0]    queue_open_mask;
  logic [MASK_W-1:0]    holds_flow_mask;
  logic [DRAW_W-1:0]    random_draw;

  modport source (
    output valid, route_weights, queue_empty_mask, queue_claimed_mask,
           queue_open_mask, holds_flow_mask, random_draw,
    input  ready
  );

  modport sink (
    input  valid, route_weights, queue_empty_mask, queue_claimed_mask,
           queue_open_mask, holds_flow_mask, random_draw,
    output ready
  );
endinterface

`default_nettype wire

### hdl/wrva_res_if.sv
// ----------------------------------------------------------------------------
// Weighted random VC allocator - result channel
// Valid/ready channel carrying one grant result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrva_res_if;
  import wrva_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] grant_status;
  logic [QUEUE_W-1:0]  granted_queue;

  modport source (
    output valid, grant_status, granted_queue,
    input  ready
  );

  modport sink (
    input  valid, grant_status, granted_queue,
    output ready
  );
endinterface

`default_nettype wire

### hdl/weighted_random_vc_allocator.sv
// ----------------------------------------------------------------------------
// Weighted random VC allocator - top level
// Picks a virtual channel queue for a flow by weighted random draw over
// the eligible queues of its route.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  req       in    valid / ready    weights, queue masks, random draw
//  res       out   valid / ready    grant status, granted queue
//  apb       in    psel / penable   flow pinning bit, queue exclusive bit
//
//  One item per cycle sustained while results are taken; a result passes
//  the scan register, then the result register, before it is shown.
//  The eight-lane prefix sum sits in the scan stage, the draw multiply in
//  the result stage.
//  Reset clears the stage valids and both policy bits.
//  A stalled result holds every stage that is full; empty stages still fill.
// ----------------------------------------------------------------------------
`default_nettype none

`include "weighted_random_vc_allocator_defines.svh"

module weighted_random_vc_allocator (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  wrva_req_if.sink                             req,
  wrva_res_if.source                           res,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wrva_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wrva_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [wrva_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import wrva_pkg::*;

  cfg_t cfg;
  req_t in_q;
  mid_t mid;
  res_t res_r;

  logic v0_q, v1_q, v2_q;
  logic en0, en1, en2;

  wrva_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage advance: a stage moves when the one after it is empty or moving
  assign en2 = !v2_q || res.ready;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign req.ready = en0;

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= req.valid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (en0 && req.valid) begin
      in_q.route_weights      <= req.route_weights;
      in_q.queue_empty_mask   <= req.queue_empty_mask;
      in_q.queue_claimed_mask <= req.queue_claimed_mask;
      in_q.queue_open_mask    <= req.queue_open_mask;
      in_q.holds_flow_mask    <= req.holds_flow_mask;
      in_q.random_draw        <= req.random_draw;
    end
  end

  wrva_elig u_elig (
    .clk_i  (clk_i),
    .load_i (en1 && v0_q),
    .cfg_i  (cfg),
    .req_i  (in_q),
    .mid_o  (mid)
  );

  wrva_pick u_pick (
    .clk_i  (clk_i),
    .load_i (en2 && v1_q),
    .mid_i  (mid),
    .res_o  (res_r)
  );

  assign res.valid         = v2_q;
  assign res.grant_status  = res_r.status;
  assign res.granted_queue = QUEUE_W'(res_r.queue);

  // Input stalls only when every stage is full and the result is held
  `WRVA_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, !req.ready,
    v0_q && v1_q && v2_q && !res.ready, "input stalled with a free stage")

  // A refused grant reports queue zero
  `WRVA_ASSERT_IMPL(a_nogrant_zero, clk_i, rst_ni,
    res.valid && (res.grant_status != ST_GRANTED),
    res.granted_queue == '0, "non-granted result names a queue")

  // A granted scan result always carries a nonzero weight sum
  `WRVA_ASSERT_IMPL(a_grant_sum, clk_i, rst_ni,
    v1_q && (mid.status == ST_GRANTED),
    (mid.sum != '0) && (mid.cand != '0), "grant with empty candidate set")

  // A held result leaves the scan stage full or not, but keeps the result
  `WRVA_ASSERT_NEXT(a_hold_res, clk_i, rst_ni, res.valid && !res.ready,
    res.valid && $stable(res_r), "held result changed")

endmodule

`default_nettype wire

### hdl/wrva_cfg_regs.sv
// ----------------------------------------------------------------------------
// Weighted random VC allocator - configuration registers
// APB-style write/read access to the two flow policy bits.
// ----------------------------------------------------------------------------
`default_nettype none

module wrva_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [wrva_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [wrva_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [wrva_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output wrva_pkg::cfg_t                       cfg_o
);
  import wrva_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Write completes in the access phase; no wait states
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Decode the register by word address
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[2])
        REG_FLOW_PINNED:     cfg_d.flow_pinned     = pwdata[0];
        REG_QUEUE_EXCLUSIVE: cfg_d.queue_exclusive = pwdata[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed bit
  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_FLOW_PINNED:     prdata[0] = cfg_q.flow_pinned;
      REG_QUEUE_EXCLUSIVE: prdata[0] = cfg_q.queue_exclusive;
      default:             prdata    = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/wrva_elig.sv
// ----------------------------------------------------------------------------
// Weighted random VC allocator - eligibility and prefix sum stage
// Marks candidate queues and registers their cumulative weights.
// ----------------------------------------------------------------------------
`default_nettype none

module wrva_elig (
  input  wire logic           clk_i,
  input  wire logic           load_i,
  input  wire wrva_pkg::cfg_t cfg_i,
  input  wire wrva_pkg::req_t req_i,
  output wrva_pkg::mid_t      mid_o
);
  import wrva_pkg::*;

  mid_t mid_q, mid_d;

  always_comb begin
    logic [NUM_QUEUES-1:0][WEIGHT_BITS-1:0] w;
    logic [NUM_QUEUES-1:0]                  in_route;
    logic [NUM_QUEUES-1:0]                  free;
    logic [NUM_QUEUES-1:0]                  base;
    logic [NUM_QUEUES-1:0]                  stop;
    logic [NUM_QUEUES-1:0]                  first_stop;
    logic                                   found;
    logic [SUM_W-1:0]                       acc;
    logic [SUM_W-1:0]                       weff;

    found      = 1'b0;
    first_stop = '0;
    acc        = '0;

    // Per-queue status
    for (int i = 0; i < NUM_QUEUES; i++) begin
      w[i]        = req_i.route_weights[LANE_W*i +: WEIGHT_BITS];
      in_route[i] = (w[i] != '0);
      free[i]     = !req_i.queue_claimed_mask[i] && req_i.queue_open_mask[i];
      // non-empty queue that carries this flow ends the scan in pinned mode
      stop[i]     = in_route[i] && !req_i.queue_empty_mask[i] &&
                    cfg_i.flow_pinned && req_i.holds_flow_mask[i];
      base[i]     = in_route[i] && free[i] &&
                    (req_i.queue_empty_mask[i] ||
                     !(cfg_i.queue_exclusive && !req_i.holds_flow_mask[i]));
    end

    // Find the first pinned queue
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (stop[i] && !found) begin
        first_stop[i] = 1'b1;
        found         = 1'b1;
      end
    end

    mid_d.cand = found ? (first_stop & free) : base;

    // Running weight sum over candidates; a pinned queue weighs one
    for (int i = 0; i < NUM_QUEUES; i++) begin
      weff = found ? SUM_W'(1) : SUM_W'(w[i]);
      if (mid_d.cand[i]) begin
        acc = acc + weff;
      end
      mid_d.cum[i] = acc;
    end

    mid_d.sum  = acc;
    mid_d.draw = RANDOM_BITS'(req_i.random_draw);

    if (in_route == '0) begin
      mid_d.status = ST_NO_ROUTE;
    end else if (mid_d.cand == '0) begin
      mid_d.status = ST_NO_ELIG;
    end else begin
      mid_d.status = ST_GRANTED;
    end
  end

  // Payload register, advances with the pipeline
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule

`default_nettype wire

### hdl/wrva_pick.sv
// ----------------------------------------------------------------------------
// Weighted random VC allocator - draw and select stage
// Scales the random draw by the weight sum and picks the first candidate
// whose cumulative weight exceeds it.
// ----------------------------------------------------------------------------
`default_nettype none

module wrva_pick (
  input  wire logic           clk_i,
  input  wire logic           load_i,
  input  wire wrva_pkg::mid_t mid_i,
  output wrva_pkg::res_t      res_o
);
  import wrva_pkg::*;

  res_t              res_q, res_d;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  thresh;

  // Scaled draw: floor(draw * sum / 2^RANDOM_BITS)
  assign prod   = PROD_W'(mid_i.draw) * PROD_W'(mid_i.sum);
  assign thresh = prod[RANDOM_BITS +: SUM_W];

  // First candidate above the threshold
  always_comb begin
    logic found;
    found        = 1'b0;
    res_d.status = mid_i.status;
    res_d.queue  = '0;
    if (mid_i.status == ST_GRANTED) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        if (!found && mid_i.cand[i] && (thresh < mid_i.cum[i])) begin
          res_d.queue = QIDX_W'(i);
          found       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### tb/tb_weighted_random_vc_allocator.sv
// ----------------------------------------------------------------------------
// Weighted random VC allocator - testbench
// Drives allocation requests through the valid/ready request channel and
// programs both policy bits over the APB port. A scoreboard predicts each
// grant from the request and the current policy, then checks every result
// item in order. The run starts with directed corner requests and then
// sends random route/mask mixes, with random idling on both channels and
// one long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_weighted_random_vc_allocator;
  import wrva_pkg::*;

  localparam int CYCLE_LIMIT       = 200000;
  localparam int HOLD_OFF_CYCLES   = 80;
  localparam int DRAIN_CYCLES      = 8;
  localparam int ITEMS_PER_GROUP   = 150;
  localparam int NUM_GROUPS        = 7;
  localparam logic [CFG_ADDR_W-1:0] ADDR_FLOW_PINNED =
      CFG_ADDR_W'({REG_FLOW_PINNED, 2'b00});
  localparam logic [CFG_ADDR_W-1:0] ADDR_QUEUE_EXCLUSIVE =
      CFG_ADDR_W'({REG_QUEUE_EXCLUSIVE, 2'b00});

  // Grant predictor and in-order store of expected grants
  class vc_grant_scoreboard;
    cfg_t policy;
    res_t grants_due[$];
    int   errors;

    function new();
      policy = '0;
      errors = 0;
    endfunction

    function res_t predict_grant(req_t r);
      res_t            g;
      int unsigned     cum[NUM_QUEUES];
      int unsigned     idx[NUM_QUEUES];
      int unsigned     n;
      int unsigned     total;
      int unsigned     w;
      int unsigned     pick;
      longint unsigned scaled;
      bit              routed;
      bit              stop;
      bit              found;
      bit              is_empty;
      bit              is_free;
      bit              owns;
      n      = 0;
      total  = 0;
      routed = 1'b0;
      stop   = 1'b0;
      found  = 1'b0;
      pick   = 0;
      g.status = ST_GRANTED;
      g.queue  = '0;
      // Scan the route queues in index order, building cumulative weights
      for (int i = 0; i < NUM_QUEUES; i++) begin
        w = 32'(r.route_weights[i*LANE_W +: WEIGHT_BITS]);
        if (!stop && w != 0) begin
          routed   = 1'b1;
          is_empty = r.queue_empty_mask[i];
          is_free  = !r.queue_claimed_mask[i] && r.queue_open_mask[i];
          owns     = r.holds_flow_mask[i];
          if (is_empty) begin
            if (is_free) begin
              total  += w;
              cum[n] = total;
              idx[n] = i;
              n++;
            end
          end else if (policy.flow_pinned && owns) begin
            // Queue already carries the flow: it is the only choice
            total = 1;
            n     = 0;
            if (is_free) begin
              cum[0] = 1;
              idx[0] = i;
              n      = 1;
            end
            stop = 1'b1;
          end else if (policy.queue_exclusive && !owns) begin
            // Busy with another flow: skip
          end else if (is_free) begin
            total  += w;
            cum[n] = total;
            idx[n] = i;
            n++;
          end
        end
      end
      if (!routed) begin
        g.status = ST_NO_ROUTE;
      end else if (n == 0) begin
        g.status = ST_NO_ELIG;
      end else begin
        // Scale the draw by the weight sum and take the first sum above it
        scaled = (longint'(r.random_draw[RANDOM_BITS-1:0]) * total) >> RANDOM_BITS;
        pick   = idx[n-1];
        for (int k = 0; k < NUM_QUEUES; k++) begin
          if (!found && k < n && scaled < cum[k]) begin
            pick  = idx[k];
            found = 1'b1;
          end
        end
        g.queue = pick[QIDX_W-1:0];
      end
      return g;
    endfunction

    function void note_request(req_t r);
      grants_due.insert(grants_due.size(), predict_grant(r));
    endfunction

    function void check_grant(logic [STATUS_W-1:0] st, logic [QUEUE_W-1:0] q);
      res_t exp_g;
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result item status=%0d queue=%0d", $time, st, q);
        errors++;
        return;
      end
      exp_g = grants_due.pop_front();
      if (st !== exp_g.status) begin
        $display("%0t: grant_status expected %0d actual %0d", $time, exp_g.status, st);
        errors++;
      end
      if (q !== QUEUE_W'(exp_g.queue)) begin
        $display("%0t: granted_queue expected %0d actual %0d", $time, exp_g.queue, q);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  wrva_req_if req_if ();
  wrva_res_if res_if ();

  vc_grant_scoreboard grant_sb = new();

  int snd_idle_pct;
  int rcv_idle_pct;
  int stall_asked;
  int stall_served;
  int stall_left;
  int cycle_count;

  weighted_random_vc_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result receiver: random idling, plus one long hold-off on request
  initial begin
    stall_served = 0;
    stall_left   = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (stall_served != stall_asked) begin
        stall_served = stall_asked;
        stall_left   = HOLD_OFF_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Check each accepted result item
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      grant_sb.check_grant(res_if.grant_status, res_if.granted_queue);
    end
  end

  // Offer one request item and hold it until accepted
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid              <= 1'b1;
    req_if.route_weights      <= r.route_weights;
    req_if.queue_empty_mask   <= r.queue_empty_mask;
    req_if.queue_claimed_mask <= r.queue_claimed_mask;
    req_if.queue_open_mask    <= r.queue_open_mask;
    req_if.holds_flow_mask    <= r.holds_flow_mask;
    req_if.random_draw        <= r.random_draw;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    grant_sb.note_request(r);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drain the block, then program both policy bits (upper bits are noise)
  task automatic set_policy(input bit oqpf, input bit ofpq);
    req_if.valid <= 1'b0;
    while (grant_sb.grants_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    apb_write(ADDR_FLOW_PINNED, ($urandom() & ~32'h1) | CFG_DATA_W'(oqpf));
    apb_write(ADDR_QUEUE_EXCLUSIVE, ($urandom() & ~32'h1) | CFG_DATA_W'(ofpq));
    grant_sb.policy.flow_pinned     = oqpf;
    grant_sb.policy.queue_exclusive = ofpq;
  endtask

  function automatic req_t make_request(logic [63:0] w, logic [7:0] em, logic [7:0] cl,
                                        logic [7:0] op, logic [7:0] hf, logic [15:0] dr);
    req_t r;
    r.route_weights      = w;
    r.queue_empty_mask   = em;
    r.queue_claimed_mask = cl;
    r.queue_open_mask    = op;
    r.holds_flow_mask    = hf;
    r.random_draw        = dr;
    return r;
  endfunction

  // Random request: mostly plausible router traffic, some noise
  function automatic req_t make_random_request();
    req_t        r;
    int unsigned style;
    int unsigned hold_q;
    style = $urandom_range(0, 9);
    r.route_weights      = {$urandom(), $urandom()};
    r.queue_empty_mask   = 8'($urandom_range(0, 255));
    r.queue_claimed_mask = 8'($urandom_range(0, 255));
    r.queue_open_mask    = 8'($urandom_range(0, 255));
    r.holds_flow_mask    = 8'($urandom_range(0, 255));
    r.random_draw        = 16'($urandom_range(0, 65535));
    if (style == 1) begin
      // No route at all
      r.route_weights = '0;
    end else if (style >= 2) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        case ($urandom_range(0, 7))
          0, 1: r.route_weights[i*LANE_W +: LANE_W] = '0;
          2: r.route_weights[i*LANE_W +: LANE_W] = 8'hFF;
          3: r.route_weights[i*LANE_W +: LANE_W] = 8'd1;
          default: r.route_weights[i*LANE_W +: LANE_W] = 8'($urandom_range(1, 255));
        endcase
      end
      r.queue_claimed_mask = 8'($urandom() & $urandom());
      r.queue_open_mask    = 8'($urandom() | $urandom());
      hold_q = $urandom_range(0, NUM_QUEUES - 1);
      case ($urandom_range(0, 3))
        0: r.holds_flow_mask = '0;
        1, 2: r.holds_flow_mask = 8'(1 << hold_q);
        default: r.holds_flow_mask = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 19))
        0: r.random_draw = 16'h0000;
        1: r.random_draw = 16'hFFFF;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Main sequence
  initial begin
    snd_idle_pct = 27;
    rcv_idle_pct = 62;
    stall_asked  = 0;
    rst_ni                    <= 1'b0;
    psel                      <= 1'b0;
    penable                   <= 1'b0;
    pwrite                    <= 1'b0;
    paddr                     <= '0;
    pwdata                    <= '0;
    req_if.valid              <= 1'b0;
    req_if.route_weights      <= '0;
    req_if.queue_empty_mask   <= '0;
    req_if.queue_claimed_mask <= '0;
    req_if.queue_open_mask    <= '0;
    req_if.holds_flow_mask    <= '0;
    req_if.random_draw        <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: default policy (reset values)
    send_request(make_request(64'h0, 8'hFF, 8'h00, 8'hFF, 8'h00, 16'h1234));
    send_request(make_request('1, 8'hFF, 8'h00, 8'hFF, 8'hFF, 16'h0000));
    send_request(make_request('1, 8'hFF, 8'h00, 8'hFF, 8'h00, 16'hFFFF));
    send_request(make_request('1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 16'h8000));
    send_request(make_request('1, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h8000));
    send_request(make_request(64'h0100_0000_0000_0000, 8'hFF, 8'h00, 8'hFF, 8'h00,
                              16'hFFFF));
    send_request(make_request(64'h0101_0101_0101_0101, 8'h00, 8'h00, 8'hFF, 8'h00,
                              16'h8000));
    send_request(make_request(64'h0F80_0F80_0F80_0F80, 8'hAA, 8'h11, 8'hEE, 8'h44,
                              16'h7FFF));
    // Directed: a flow already in a queue sticks to it
    set_policy(1'b1, 1'b0);
    send_request(make_request('1, 8'h00, 8'h00, 8'hFF, 8'h08, 16'hFFFF));
    send_request(make_request('1, 8'h00, 8'h08, 8'hFF, 8'h08, 16'h0000));
    send_request(make_request('1, 8'hFF, 8'h00, 8'hFF, 8'h04, 16'hC000));
    send_request(make_request(64'h0000_0000_FF00_0000, 8'h00, 8'h00, 8'hF7, 8'h08,
                              16'h5555));
    // Directed: a busy queue with another flow is off limits
    set_policy(1'b0, 1'b1);
    send_request(make_request('1, 8'h00, 8'h00, 8'hFF, 8'h10, 16'hFFFF));
    send_request(make_request('1, 8'h00, 8'h00, 8'hFF, 8'h00, 16'h4000));
    send_request(make_request('1, 8'h0F, 8'h00, 8'hFF, 8'h00, 16'hFFFF));
    // Directed: both policies
    set_policy(1'b1, 1'b1);
    send_request(make_request('1, 8'h01, 8'h00, 8'hFF, 8'h40, 16'h0000));
    send_request(make_request('1, 8'h00, 8'h00, 8'hFF, 8'h00, 16'h9000));
    send_request(make_request(64'hFF01_0203_0405_0607, 8'h3C, 8'h00, 8'hFF, 8'h80,
                              16'hFFFF));

    // Random groups: policy and idling pattern set per group
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (g < 2) begin
        snd_idle_pct = 27;
        rcv_idle_pct = 62;
      end else if (g < 4) begin
        snd_idle_pct = 62;
        rcv_idle_pct = 27;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      case (g)
        0, 5: set_policy(1'b0, 1'b0);
        1, 4: set_policy(1'b1, 1'b1);
        2, 6: set_policy(1'b1, 1'b0);
        default: set_policy(1'b0, 1'b1);
      endcase
      // Hold results off while the sender keeps offering items
      if (g == 5) stall_asked = stall_asked + 1;
      for (int n = 0; n < ITEMS_PER_GROUP; n++) begin
        send_request(make_random_request());
      end
    end

    // Wait for the last grants, then report
    req_if.valid <= 1'b0;
    while (grant_sb.grants_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (grant_sb.errors == 0 && grant_sb.grants_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/wrva_pkg.sv
hdl/wrva_req_if.sv
hdl/wrva_res_if.sv
hdl/wrva_cfg_regs.sv
hdl/wrva_elig.sv
hdl/wrva_pick.sv
hdl/weighted_random_vc_allocator.sv
tb/tb_weighted_random_vc_allocator.sv
